// ===== hdl/sst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, codes and field widths of the sorted slot table.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int DEF_MAX_SLOTS = 64;

	// command word fields
	localparam int CMD_W      = 3;
	localparam int SLOT_W     = 6;
	localparam int X_W        = 32;
	localparam int POS_W      = 6;
	localparam int IN_TDATA_W = 112;

	// result word fields
	localparam int STATUS_W    = 2;
	localparam int FOUND_W     = 7;
	localparam int TOTAL_W     = 7;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - SLOT_W - FOUND_W - TOTAL_W;

	// common width for slot and position compares (covers up to 255 slots)
	localparam int CMP_W = 8;

	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SORT   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_REJECT  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD_WR,
		ST_LOC_RD,
		ST_LOC_CMP,
		ST_REM_RD,
		ST_REM_WR,
		ST_SET_WR,
		ST_SRT_CUR,
		ST_SRT_KEY,
		ST_SRT_KEYW,
		ST_SRT_CHK,
		ST_SRT_PRV,
		ST_SRT_CMP,
		ST_FND_CHK,
		ST_FND_AL,
		ST_FND_CMP,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/sorted_slot_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_slot_table
// Slot table with free stack, sorted active list, search and readback.
// ----------------------------------------------------------------------------
// One command word enters on the s_ channel (command kind on s_tuser), one
// result word leaves on the m_ channel for every command. s_tready is high only
// while the sequencer is idle; one command is worked on at a time, and the next
// is taken while a finished result still waits in the output register.
// Work per command, from accept to result valid, is all set by the single read
// port of the active list memory with its registered read data:
//   add, read: one list access (none if rejected or out of range); 6, 7: none
//   remove and set extent one list read per position scanned up to the match
//   find one list read per halving step of the search window
//   sort one pass per entry after the first, one swap step per position an entry
//   moves, and one more compare for an entry that stops short of the front
// When the receiver stalls, the result holds in the output register and the
// sequencer parks in its done state after finishing the following command.
// Reset clears the active and free counts and the handshake; the slot, list
// and free stack memories hold no reset value and are only read where written.
// ----------------------------------------------------------------------------
module sorted_slot_table #(
	parameter int MAX_SLOTS = sst_pkg::DEF_MAX_SLOTS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// entry_valid, slot, min_x, max_x, list_position, query_x, zero pad
	input  wire logic [sst_pkg::IN_TDATA_W-1:0]     s_tdata,
	// command
	input  wire logic [sst_pkg::CMD_W-1:0]          s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// status, result_slot, found_position, active_total, zero pad
	output logic [sst_pkg::OUT_TDATA_W-1:0]         m_tdata
);
	import sst_pkg::*;

	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	state_t state_q, state_nxt;

	logic [CMD_W-1:0]    cmd_q;
	logic                valid_q;
	logic [SLOT_W-1:0]   slot_q;
	logic signed [X_W-1:0] lo_q, hi_q, qx_q;
	logic [POS_W-1:0]    pos_q;

	logic [CNT_W-1:0] act_cnt_q, free_cnt_q;
	logic [CNT_W-1:0] idx_q, jdx_q, mid_q;
	logic [IDX_W-1:0] loc_q, cur_q, tmp_q;
	logic signed [X_W-1:0] key_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_slot_q;
	logic [CNT_W-1:0]    res_found_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// memories
	logic [IDX_W-1:0]      al_mem [MAX_SLOTS];
	logic [IDX_W-1:0]      fs_mem [MAX_SLOTS];
	logic signed [X_W-1:0] lo_mem [MAX_SLOTS];
	logic signed [X_W-1:0] hi_mem [MAX_SLOTS];

	logic [IDX_W-1:0]      al_rd_q, fs_rd_q;
	logic signed [X_W-1:0] lo_rd_q, hi_rd_q;

	logic             al_we, fs_we, ext_we;
	logic [IDX_W-1:0] al_waddr, al_wdata, ext_waddr, al_raddr, fs_raddr, lo_raddr, hi_raddr;

	// shared compares
	logic             accept, idx_lt_act, act_lt_max, free_full, slot_match, pos_lt_act;
	logic             sort_move, find_right, out_free;
	logic [CNT_W-1:0] mid;
	logic [IDX_W-1:0] add_n;

	assign accept     = s_tvalid && s_tready;
	assign idx_lt_act = idx_q < act_cnt_q;
	assign act_lt_max = act_cnt_q < CNT_W'(MAX_SLOTS);
	assign free_full  = free_cnt_q >= CNT_W'(MAX_SLOTS);
	assign slot_match = CMP_W'(al_rd_q) == CMP_W'(slot_q);
	assign pos_lt_act = CMP_W'(pos_q) < CMP_W'(act_cnt_q);
	assign sort_move  = lo_rd_q > key_q;
	assign find_right = hi_rd_q < qx_q;
	assign out_free   = !m_tvalid_q || m_tready;
	assign mid        = idx_q + ((jdx_q - idx_q) >> 1);
	assign add_n      = (free_cnt_q != '0) ? fs_rd_q : act_cnt_q[IDX_W-1:0];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (cmd_q)
					CMD_ADD:    state_nxt = (valid_q && act_lt_max) ? ST_ADD_WR : ST_DONE;
					CMD_REMOVE: state_nxt = ST_LOC_RD;
					CMD_SET:    state_nxt = ST_LOC_RD;
					CMD_SORT:   state_nxt = ST_SRT_CUR;
					CMD_FIND:   state_nxt = ST_FND_CHK;
					CMD_READ:   state_nxt = pos_lt_act ? ST_RD_WAIT : ST_DONE;
					default:    state_nxt = ST_DONE;
				endcase
			end
			ST_ADD_WR: state_nxt = ST_DONE;
			ST_LOC_RD: state_nxt = idx_lt_act ? ST_LOC_CMP : ST_DONE;
			ST_LOC_CMP: begin
				if (!slot_match) state_nxt = ST_LOC_RD;
				else if (cmd_q == CMD_SET) state_nxt = ST_SET_WR;
				else if (free_full) state_nxt = ST_DONE;
				else state_nxt = ST_REM_RD;
			end
			ST_REM_RD:   state_nxt = ST_REM_WR;
			ST_REM_WR:   state_nxt = ST_DONE;
			ST_SET_WR:   state_nxt = ST_DONE;
			ST_SRT_CUR:  state_nxt = idx_lt_act ? ST_SRT_KEY : ST_DONE;
			ST_SRT_KEY:  state_nxt = ST_SRT_KEYW;
			ST_SRT_KEYW: state_nxt = ST_SRT_CHK;
			ST_SRT_CHK:  state_nxt = (jdx_q != '0) ? ST_SRT_PRV : ST_SRT_CUR;
			ST_SRT_PRV:  state_nxt = ST_SRT_CMP;
			ST_SRT_CMP:  state_nxt = sort_move ? ST_SRT_CHK : ST_SRT_CUR;
			ST_FND_CHK:  state_nxt = (idx_q < jdx_q) ? ST_FND_AL : ST_DONE;
			ST_FND_AL:   state_nxt = ST_FND_CMP;
			ST_FND_CMP:  state_nxt = ST_FND_CHK;
			ST_RD_WAIT:  state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		al_we     = 1'b0;
		al_waddr  = act_cnt_q[IDX_W-1:0];
		al_wdata  = add_n;
		fs_we     = 1'b0;
		ext_we    = 1'b0;
		ext_waddr = add_n;
		al_raddr  = idx_q[IDX_W-1:0];
		fs_raddr  = IDX_W'(free_cnt_q - CNT_W'(1));
		lo_raddr  = al_rd_q;
		hi_raddr  = al_rd_q;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_DISPATCH: al_raddr = IDX_W'(pos_q);
			ST_ADD_WR: begin
				al_we  = 1'b1;
				ext_we = 1'b1;
			end
			ST_REM_RD: al_raddr = IDX_W'(act_cnt_q - CNT_W'(1));
			ST_REM_WR: begin
				al_we    = 1'b1;
				al_waddr = loc_q;
				al_wdata = al_rd_q;
				fs_we    = 1'b1;
			end
			ST_SET_WR: begin
				ext_we    = 1'b1;
				ext_waddr = IDX_W'(slot_q);
			end
			ST_SRT_CHK: begin
				al_raddr = IDX_W'(jdx_q - CNT_W'(1));
				if (jdx_q == '0) begin
					al_we    = 1'b1;
					al_waddr = jdx_q[IDX_W-1:0];
					al_wdata = cur_q;
				end
			end
			ST_SRT_CMP: begin
				al_we    = 1'b1;
				al_waddr = jdx_q[IDX_W-1:0];
				al_wdata = sort_move ? tmp_q : cur_q;
			end
			ST_FND_CHK: al_raddr = mid[IDX_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (al_we) al_mem[al_waddr] <= al_wdata;
		al_rd_q <= al_mem[al_raddr];
	end

	always_ff @(posedge clk) begin
		if (fs_we) fs_mem[free_cnt_q[IDX_W-1:0]] <= IDX_W'(slot_q);
		fs_rd_q <= fs_mem[fs_raddr];
	end

	always_ff @(posedge clk) begin
		if (ext_we) begin
			lo_mem[ext_waddr] <= lo_q;
			hi_mem[ext_waddr] <= hi_q;
		end
		lo_rd_q <= lo_mem[lo_raddr];
		hi_rd_q <= hi_mem[hi_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			act_cnt_q  <= '0;
			free_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_ADD_WR) begin
				act_cnt_q <= act_cnt_q + CNT_W'(1);
				if (free_cnt_q != '0) free_cnt_q <= free_cnt_q - CNT_W'(1);
			end
			if (state_q == ST_REM_WR) begin
				act_cnt_q  <= act_cnt_q - CNT_W'(1);
				free_cnt_q <= free_cnt_q + CNT_W'(1);
			end
			if (state_q == ST_DONE && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q   <= s_tuser;
					valid_q <= s_tdata[0];
					slot_q  <= s_tdata[6:1];
					lo_q    <= s_tdata[38:7];
					hi_q    <= s_tdata[70:39];
					pos_q   <= s_tdata[76:71];
					qx_q    <= s_tdata[108:77];
				end
			end
			ST_DISPATCH: begin
				res_slot_q   <= '0;
				res_found_q  <= '0;
				idx_q        <= (cmd_q == CMD_SORT) ? CNT_W'(1) : '0;
				jdx_q        <= act_cnt_q;
				if (cmd_q == CMD_ADD && !(valid_q && act_lt_max)) res_status_q <= STAT_REJECT;
				else if (cmd_q == CMD_READ && !pos_lt_act) res_status_q <= STAT_MISSING;
				else res_status_q <= STAT_OK;
			end
			ST_ADD_WR: res_slot_q <= add_n;
			ST_LOC_RD: begin
				if (!idx_lt_act) res_status_q <= STAT_MISSING;
			end
			ST_LOC_CMP: begin
				loc_q <= idx_q[IDX_W-1:0];
				if (!slot_match) idx_q <= idx_q + CNT_W'(1);
				else if (cmd_q == CMD_REMOVE && free_full) res_status_q <= STAT_MISSING;
			end
			ST_SRT_CUR: jdx_q <= idx_q;
			ST_SRT_KEY: cur_q <= al_rd_q;
			ST_SRT_KEYW: key_q <= lo_rd_q;
			ST_SRT_CHK: begin
				if (jdx_q == '0) idx_q <= idx_q + CNT_W'(1);
			end
			ST_SRT_PRV: tmp_q <= al_rd_q;
			ST_SRT_CMP: begin
				if (sort_move) jdx_q <= jdx_q - CNT_W'(1);
				else idx_q <= idx_q + CNT_W'(1);
			end
			ST_FND_CHK: begin
				mid_q <= mid;
				if (!(idx_q < jdx_q)) res_found_q <= idx_q;
			end
			ST_FND_CMP: begin
				if (find_right) idx_q <= mid_q + CNT_W'(1);
				else jdx_q <= mid_q;
			end
			ST_RD_WAIT: res_slot_q <= al_rd_q;
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {{OUT_PAD_W{1'b0}}, TOTAL_W'(act_cnt_q),
						FOUND_W'(res_found_q), SLOT_W'(res_slot_q), res_status_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_act_bound: assert property (@(posedge clk) disable iff (!arst_n)
		act_cnt_q <= CNT_W'(MAX_SLOTS))
		else $error("active count above table size");

	a_slot_budget: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, act_cnt_q} + {1'b0, free_cnt_q}) <= (CNT_W + 1)'(MAX_SLOTS))
		else $error("active and free slots exceed table size");

	a_sort_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRT_CHK |-> jdx_q <= idx_q && idx_q < act_cnt_q)
		else $error("insertion index out of order");

	a_find_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FND_CHK |-> idx_q <= jdx_q && jdx_q <= act_cnt_q)
		else $error("search window out of range");

	a_done_hands_off: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> state_q == ST_IDLE && m_tvalid_q)
		else $error("finished command did not reach the output register");
`endif

endmodule
`default_nettype wire
